// ===== hw/rtl/tbm_pkg.sv =====
// command and result word types and op codes for the thread barrier manager
`timescale 1ns / 1ps
`default_nettype none

package tbm_pkg;

    // event codes
    localparam logic [2:0] OP_CREATE = 3'd0;
    localparam logic [2:0] OP_JOIN   = 3'd1;
    localparam logic [2:0] OP_START  = 3'd2;
    localparam logic [2:0] OP_WAIT   = 3'd3;
    localparam logic [2:0] OP_STOP   = 3'd4;
    localparam logic [2:0] OP_EXIT   = 3'd5;

    // saturation point of a barrier's waiting count
    localparam logic [3:0] WCOUNT_MAX = 4'hF;

    // command word
    typedef struct packed {
        logic [2:0]  op;
        logic [2:0]  thread_id;
        logic [3:0]  barrier_id;
        logic        ended_on_barrier;
        logic [15:0] exit_value;
    } cmd_t;

    // result word
    typedef struct packed {
        logic [7:0]  active_mask;
        logic        released;
        logic        all_stopped;
        logic        exited;
        logic [15:0] exit_code;
    } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/thread_barrier_manager.sv =====
// thread barrier manager: barrier table in memory, thread masks in registers
`timescale 1ns / 1ps
`default_nettype none

// A command word is accepted at a rising edge where start is high and busy is
// low; that same edge reads the barrier's entry (member set, member count,
// waiting count) from the barrier table, a single-port memory with a registered
// read. In the next cycle busy is high while the thread masks and the
// entry are updated, and the entry is written back at the end of that cycle.
// The result word appears on result with done high for one cycle, the cycle
// right after the busy cycle; it cannot be held off and must be taken then.
// A new command can already be accepted in the done cycle; commands are
// refused only while busy is high. Commands that do not concern a barrier
// (create, start, exit) go through the same busy and done cycles. Barrier
// entries read as empty until first written; valid bits cleared at reset
// stand in for a clearing pass, so the block is ready right after reset.
module thread_barrier_manager #(
    parameter int MAX_THREADS  = 8,
    parameter int NUM_BARRIERS = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire tbm_pkg::cmd_t    cmd,
    output logic                  busy,
    output logic                  done,
    output tbm_pkg::result_t      result
);

    localparam int BW = (NUM_BARRIERS > 1) ? $clog2(NUM_BARRIERS) : 1;
    localparam int CW = $clog2(MAX_THREADS + 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    typedef struct packed {
        logic [MAX_THREADS-1:0] members;
        logic [CW-1:0]          mcount;
        logic [3:0]             wcount;
    } entry_t;

    // barrier table and its valid bits
    entry_t                   table_mem [NUM_BARRIERS];
    logic [NUM_BARRIERS-1:0]  valid_reg;

    logic                     state_reg;
    logic                     done_reg;
    tbm_pkg::result_t         result_reg;
    tbm_pkg::cmd_t            cmd_reg;
    logic                     bar_ok_reg;
    logic [BW-1:0]            bidx_reg;
    entry_t                   rd_reg;
    logic                     vld_rd_reg;

    logic [MAX_THREADS-1:0]   created_reg, created_next;
    logic [MAX_THREADS-1:0]   running_reg, running_next;
    logic [MAX_THREADS-1:0]   stopped_reg, stopped_next;
    logic                     halted_reg, halted_next;
    logic [15:0]              latched_reg, latched_next;

    logic                     accept;
    logic [BW+3:0]            in_bid_wide;
    logic [BW-1:0]            in_bidx;
    logic                     in_bar_ok;

    entry_t                   rd_entry;
    entry_t                   wr_entry;
    logic                     wr_en;
    logic                     released;
    logic                     tid_ok;
    logic [MAX_THREADS-1:0]   tbit;
    logic                     is_running;
    logic [3:0]               wc_inc;
    logic                     was_member;
    logic [MAX_THREADS-1:0]   members_new;
    logic [CW-1:0]            mcount_new;
    logic [MAX_THREADS+7:0]   run_wide;

    // input side decode
    assign accept      = start && !busy;
    assign in_bid_wide = {{BW{1'b0}}, cmd.barrier_id};
    assign in_bidx     = in_bid_wide[BW-1:0];
    assign in_bar_ok   = 32'(cmd.barrier_id) < 32'(NUM_BARRIERS);

    assign busy   = state_reg == ST_EXEC;
    assign done   = done_reg;
    assign result = result_reg;

    // command capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= cmd;
            bar_ok_reg <= in_bar_ok;
            bidx_reg   <= in_bidx;
        end
    end

    // barrier table read and write back
    always_ff @(posedge clk)
    begin
        if (accept && in_bar_ok)
        begin
            rd_reg <= table_mem[in_bidx];
        end
        if (wr_en)
        begin
            table_mem[bidx_reg] <= wr_entry;
        end
    end

    // valid bits of the table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            vld_rd_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                vld_rd_reg <= in_bar_ok && valid_reg[in_bidx];
            end
            if (wr_en)
            begin
                valid_reg[bidx_reg] <= 1'b1;
            end
        end
    end

    assign rd_entry = vld_rd_reg ? rd_reg : '0;
    assign tid_ok   = 32'(cmd_reg.thread_id) < 32'(MAX_THREADS);
    assign tbit     = {{(MAX_THREADS-1){1'b0}}, 1'b1} << cmd_reg.thread_id;
    assign is_running = |(running_reg & tbit);
    assign wc_inc   = (rd_entry.wcount == tbm_pkg::WCOUNT_MAX) ?
                      rd_entry.wcount : rd_entry.wcount + 4'd1;
    assign was_member  = |(rd_entry.members & tbit);
    assign members_new = rd_entry.members & ~tbit;
    assign mcount_new  = was_member ? rd_entry.mcount - CW'(1) : rd_entry.mcount;

    // event update, only in the busy cycle
    always_comb
    begin
        created_next = created_reg;
        running_next = running_reg;
        stopped_next = stopped_reg;
        halted_next  = halted_reg;
        latched_next = latched_reg;
        wr_en        = 1'b0;
        wr_entry     = rd_entry;
        released     = 1'b0;
        if (state_reg == ST_EXEC && !halted_reg && tid_ok)
        begin
            unique case (cmd_reg.op)
                tbm_pkg::OP_CREATE:
                begin
                    created_next = created_reg | tbit;
                end
                tbm_pkg::OP_JOIN:
                begin
                    if (bar_ok_reg && |(created_reg & tbit))
                    begin
                        wr_en            = 1'b1;
                        wr_entry.members = rd_entry.members | tbit;
                        if (!was_member)
                        begin
                            wr_entry.mcount = rd_entry.mcount + CW'(1);
                        end
                    end
                end
                tbm_pkg::OP_START:
                begin
                    if (running_reg == '0)
                    begin
                        running_next = created_reg & ~stopped_reg;
                    end
                end
                tbm_pkg::OP_WAIT:
                begin
                    if (is_running && bar_ok_reg)
                    begin
                        running_next = running_reg & ~tbit;
                        wr_en        = 1'b1;
                        if (8'(wc_inc) == 8'(rd_entry.mcount) && wc_inc != 4'd0)
                        begin
                            released        = 1'b1;
                            wr_entry.wcount = 4'd0;
                            running_next    = (running_reg & ~tbit) |
                                              (rd_entry.members & ~stopped_reg);
                        end
                        else
                        begin
                            wr_entry.wcount = wc_inc;
                        end
                    end
                end
                tbm_pkg::OP_STOP:
                begin
                    if (is_running)
                    begin
                        running_next = running_reg & ~tbit;
                        stopped_next = stopped_reg | tbit;
                        if (cmd_reg.ended_on_barrier && bar_ok_reg)
                        begin
                            wr_en            = 1'b1;
                            wr_entry.members = members_new;
                            wr_entry.mcount  = mcount_new;
                            if (8'(rd_entry.wcount) == 8'(mcount_new) &&
                                rd_entry.wcount != 4'd0)
                            begin
                                released        = 1'b1;
                                wr_entry.wcount = 4'd0;
                                running_next    = (running_reg & ~tbit) |
                                                  (members_new & ~(stopped_reg | tbit));
                            end
                        end
                    end
                end
                tbm_pkg::OP_EXIT:
                begin
                    if (is_running)
                    begin
                        halted_next  = 1'b1;
                        latched_next = cmd_reg.exit_value;
                    end
                end
                default:
                begin
                    halted_next = halted_reg;
                end
            endcase
        end
    end

    // control state and thread masks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            done_reg    <= 1'b0;
            created_reg <= '0;
            running_reg <= '0;
            stopped_reg <= '0;
            halted_reg  <= 1'b0;
            latched_reg <= '0;
        end
        else
        begin
            done_reg <= state_reg == ST_EXEC;
            if (state_reg == ST_EXEC)
            begin
                state_reg   <= ST_IDLE;
                created_reg <= created_next;
                running_reg <= running_next;
                stopped_reg <= stopped_next;
                halted_reg  <= halted_next;
                latched_reg <= latched_next;
            end
            else if (accept)
            begin
                state_reg <= ST_EXEC;
            end
        end
    end

    // result word
    assign run_wide = {8'd0, running_next};

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EXEC)
        begin
            result_reg.active_mask <= run_wide[7:0];
            result_reg.released    <= released;
            result_reg.all_stopped <= (created_next != '0) &&
                                      ((created_next & ~stopped_next) == '0);
            result_reg.exited      <= halted_next;
            result_reg.exit_code   <= halted_next ? latched_next : 16'd0;
        end
    end

endmodule

`default_nettype wire
